>>> rtl/hdu_pkg.sv
package hdu_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned SHIFT_W  = 10;
    localparam int unsigned COUNT_W  = 4;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;
    localparam logic [COUNT_W-1:0]  FRAME_BITS       = 4'd10;

    // link mode codes; the unused code behaves as idle
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [COUNT_W-1:0]  bits_left;
        logic [SHIFT_W-1:0]  shift;
        logic [PERIOD_W-1:0] tick_count;
        logic                prev_rx;
        logic                line_out;
    } t_state;

    typedef struct packed {
        logic       tx_level;
        logic       tx_accepted;
        logic       tx_done;
        logic       rx_done;
        logic [7:0] rx_byte;
        logic       rx_frame_error;
        logic       busy_res;
    } t_result;

endpackage

>>> rtl/half_duplex_uart_8n1.sv
// Half-duplex 8N1 UART, one input transaction per bit-timing tick.
// The result of a transaction is loaded into the output register when it is accepted
//   and held there while stalled; the output register is the only stage.
// Throughput: one transaction per cycle unless a stalled result is still waiting.
// Reset (synchronous, active low): idle, both lines high, bit period 104, output empty.
module half_duplex_uart_8n1 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_rx_level,
    input  logic        i_tx_request,
    input  logic [7:0]  i_tx_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tx_level,
    output logic        o_tx_accepted,
    output logic        o_tx_done,
    output logic        o_rx_done,
    output logic [7:0]  o_rx_byte,
    output logic        o_rx_frame_error,
    output logic        o_busy_res,
    // configuration channel: bit period
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_bit_period
);

    logic                         in_accept;
    logic [hdu_pkg::PERIOD_W-1:0] r_bit_period;
    hdu_pkg::t_state              r_state;
    hdu_pkg::t_state              n_state;
    hdu_pkg::t_result             r_result;
    hdu_pkg::t_result             n_result;
    logic                         r_out_valid;

    // Hold the input only while a finished result is still waiting downstream.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    // The user must configure only while idle; the block does not enforce this and ties o_cfg_ready high.
    assign o_cfg_ready = 1'b1;

    // One tick of the link: timer, framing and shift logic.
    hdu_step u_step (
        .i_state      (r_state),
        .i_bit_period (r_bit_period),
        .i_rx_level   (i_rx_level),
        .i_tx_request (i_tx_request),
        .i_tx_data    (i_tx_data),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Link state: advance only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= hdu_pkg::MODE_IDLE;
            r_state.bits_left  <= '0;
            r_state.shift      <= '0;
            r_state.tick_count <= '0;
            r_state.prev_rx    <= 1'b1;
            r_state.line_out   <= 1'b1;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Bit period register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= hdu_pkg::BIT_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bit_period <= i_cfg_bit_period;
        end
    end

    // Output register: load on accept, hold while stalled, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= in_accept || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_level       = r_result.tx_level;
    assign o_tx_accepted    = r_result.tx_accepted;
    assign o_tx_done        = r_result.tx_done;
    assign o_rx_done        = r_result.rx_done;
    assign o_rx_byte        = r_result.rx_byte;
    assign o_rx_frame_error = r_result.rx_frame_error;
    assign o_busy_res       = r_result.busy_res;

endmodule

>>> rtl/hdu_step.sv
module hdu_step (
    input  hdu_pkg::t_state                   i_state,
    input  logic [hdu_pkg::PERIOD_W-1:0]      i_bit_period,
    input  logic                              i_rx_level,
    input  logic                              i_tx_request,
    input  logic [7:0]                        i_tx_data,
    output hdu_pkg::t_state                   o_state,
    output hdu_pkg::t_result                  o_result
);

    logic                          fires;
    logic [hdu_pkg::PERIOD_W-1:0]  half_period;

    assign fires       = (i_state.tick_count <= 16'd1);
    assign half_period = {1'b0, i_bit_period[hdu_pkg::PERIOD_W-1:1]};

    always_comb begin
        o_state         = i_state;
        o_result        = '0;
        o_state.prev_rx = i_rx_level;
        unique case (i_state.mode)
            hdu_pkg::MODE_RX: begin
                if (!fires) begin
                    o_state.tick_count = i_state.tick_count - 16'd1;
                end else if (i_state.bits_left == '0) begin
                    // frame check: start low, stop high
                    o_result.rx_done = 1'b1;
                    if (!i_state.shift[0] && i_state.shift[9]) begin
                        o_result.rx_byte = i_state.shift[8:1];
                    end else begin
                        o_result.rx_frame_error = 1'b1;
                    end
                    o_state.mode = hdu_pkg::MODE_IDLE;
                end else begin
                    o_state.shift      = {i_rx_level, i_state.shift[hdu_pkg::SHIFT_W-1:1]};
                    o_state.bits_left  = i_state.bits_left - 4'd1;
                    o_state.tick_count = i_bit_period;
                end
            end
            hdu_pkg::MODE_TX: begin
                if (!fires) begin
                    o_state.tick_count = i_state.tick_count - 16'd1;
                end else if (i_state.bits_left == '0) begin
                    o_result.tx_done = 1'b1;
                    o_state.line_out = 1'b1;
                    o_state.mode     = hdu_pkg::MODE_IDLE;
                end else begin
                    o_state.line_out   = i_state.shift[0];
                    o_state.shift      = {1'b0, i_state.shift[hdu_pkg::SHIFT_W-1:1]};
                    o_state.bits_left  = i_state.bits_left - 4'd1;
                    o_state.tick_count = i_bit_period;
                end
            end
            default: begin
                if (i_state.prev_rx && !i_rx_level) begin
                    o_state.mode       = hdu_pkg::MODE_RX;
                    o_state.shift      = '0;
                    o_state.bits_left  = hdu_pkg::FRAME_BITS;
                    o_state.tick_count = half_period;
                end else if (i_tx_request) begin
                    o_result.tx_accepted = 1'b1;
                    o_state.mode         = hdu_pkg::MODE_TX;
                    o_state.shift        = {1'b1, i_tx_data, 1'b0};
                    o_state.bits_left    = hdu_pkg::FRAME_BITS;
                    o_state.tick_count   = half_period;
                    o_state.line_out     = 1'b1;
                end
            end
        endcase
        o_result.tx_level = o_state.line_out;
        o_result.busy_res = (o_state.mode == hdu_pkg::MODE_RX) ||
                            (o_state.mode == hdu_pkg::MODE_TX);
    end

endmodule

>>> rtl/hdu_checker.sv
module hdu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_tx_level,
    input logic       o_tx_accepted,
    input logic       o_tx_done,
    input logic       o_rx_done,
    input logic [7:0] o_rx_byte,
    input logic       o_rx_frame_error,
    input logic       o_busy_res
);

    // A finished stop bit leaves the line high and the link idle.
    a_tx_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_done |-> o_tx_level && !o_busy_res)
        else $error("tx_done with line low or link busy");

    // A framing error comes only with a frame check and carries no byte.
    a_ferr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rx_frame_error |-> o_rx_done && (o_rx_byte == 8'd0))
        else $error("frame error outside a frame check or with data");

    // A taken request starts a transmission: busy, line still high.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_accepted |-> o_busy_res && o_tx_level && !o_rx_done)
        else $error("accepted request without busy link");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rx_byte)
            && $stable(o_tx_level) && $stable(o_busy_res))
        else $error("stalled result changed");

endmodule

bind half_duplex_uart_8n1 hdu_checker u_hdu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_tx_level       (o_tx_level),
    .o_tx_accepted    (o_tx_accepted),
    .o_tx_done        (o_tx_done),
    .o_rx_done        (o_rx_done),
    .o_rx_byte        (o_rx_byte),
    .o_rx_frame_error (o_rx_frame_error),
    .o_busy_res       (o_busy_res)
);

>>> tb/half_duplex_uart_8n1_tb.sv
`timescale 1ns / 1ps

// Drives bit-timing ticks into the UART as input transactions: well-formed receive
// frames, transmit requests and line noise. A scoreboard predicts the result
// transaction of every tick and compares it field by field as it arrives.
module half_duplex_uart_8n1_tb;

    // how long the result side holds off in its two long back-pressure stretches
    localparam int unsigned HOLD_CYCLES = 80;

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_START,   // start bit too short, sampled high
        FLAW_STOP,    // stop bit driven low
        FLAW_RATE     // line runs at a slightly different bit rate
    } t_frame_flaw;

    // Tracks the transceiver state and holds the predicted results in order.
    class uart_scoreboard;
        logic [hdu_pkg::PERIOD_W-1:0] bit_period;
        logic [1:0]                   link_mode;
        logic [hdu_pkg::COUNT_W-1:0]  bits_left;
        logic [hdu_pkg::SHIFT_W-1:0]  shift;
        logic [hdu_pkg::PERIOD_W-1:0] tick_count;
        logic                         prev_rx;
        logic                         line_out;
        hdu_pkg::t_result             expected_q[$];
        int unsigned                  errors;

        function new();
            bit_period = hdu_pkg::BIT_PERIOD_RESET;
            link_mode  = hdu_pkg::MODE_IDLE;
            bits_left  = '0;
            shift      = '0;
            tick_count = '0;
            prev_rx    = 1'b1;
            line_out   = 1'b1;
            errors     = 0;
        endfunction

        function void set_period(logic [hdu_pkg::PERIOD_W-1:0] period);
            bit_period = period;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // True when the bit timer expires on this tick; count down otherwise.
        function bit timer_expired();
            if (tick_count > 1) begin
                tick_count = tick_count - 1'b1;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // Advance the state by one accepted tick and queue the result it yields.
        function void note_input(logic rx, logic req, logic [7:0] data);
            hdu_pkg::t_result r;
            r = '0;
            case (link_mode)
                hdu_pkg::MODE_RX: begin
                    if (timer_expired()) begin
                        if (bits_left == 0) begin
                            r.rx_done = 1'b1;
                            // stop must be high, start must be low
                            if (shift[hdu_pkg::SHIFT_W-1] && !shift[0]) begin
                                r.rx_byte = shift[8:1];
                            end else begin
                                r.rx_frame_error = 1'b1;
                            end
                            link_mode = hdu_pkg::MODE_IDLE;
                        end else begin
                            shift      = {rx, shift[hdu_pkg::SHIFT_W-1:1]};
                            bits_left  = bits_left - 1'b1;
                            tick_count = bit_period;
                        end
                    end
                end
                hdu_pkg::MODE_TX: begin
                    if (timer_expired()) begin
                        if (bits_left == 0) begin
                            r.tx_done = 1'b1;
                            line_out  = 1'b1;
                            link_mode = hdu_pkg::MODE_IDLE;
                        end else begin
                            line_out   = shift[0];
                            shift      = {1'b0, shift[hdu_pkg::SHIFT_W-1:1]};
                            bits_left  = bits_left - 1'b1;
                            tick_count = bit_period;
                        end
                    end
                end
                default: begin
                    // a falling edge beats a request on the same tick
                    if (prev_rx && !rx) begin
                        link_mode  = hdu_pkg::MODE_RX;
                        shift      = '0;
                        bits_left  = hdu_pkg::FRAME_BITS;
                        tick_count = bit_period >> 1;
                    end else if (req) begin
                        link_mode     = hdu_pkg::MODE_TX;
                        r.tx_accepted = 1'b1;
                        shift         = {1'b1, data, 1'b0};
                        bits_left     = hdu_pkg::FRAME_BITS;
                        tick_count    = bit_period >> 1;
                        line_out      = 1'b1;
                    end
                end
            endcase
            prev_rx    = rx;
            r.tx_level = line_out;
            r.busy_res = (link_mode == hdu_pkg::MODE_RX) || (link_mode == hdu_pkg::MODE_TX);
            expected_q.push_back(r);
        endfunction

        task report_error(string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report_error($sformatf("%s got 0x%h, expected 0x%h", name, got, want));
            end
        endtask

        task check_result(hdu_pkg::t_result got);
            hdu_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report_error("result transaction with nothing pending");
                return;
            end
            want = expected_q.pop_front();
            check_field("tx_level", 8'(got.tx_level), 8'(want.tx_level));
            check_field("tx_accepted", 8'(got.tx_accepted), 8'(want.tx_accepted));
            check_field("tx_done", 8'(got.tx_done), 8'(want.tx_done));
            check_field("rx_done", 8'(got.rx_done), 8'(want.rx_done));
            check_field("rx_byte", got.rx_byte, want.rx_byte);
            check_field("rx_frame_error", 8'(got.rx_frame_error),
                        8'(want.rx_frame_error));
            check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        endtask
    endclass

    // clock, reset and stimulus; every input starts at a known value
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        rx_level       = 1'b1;
    logic        tx_request     = 1'b0;
    logic [7:0]  tx_data        = 8'h00;
    logic        out_stall      = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic [15:0] cfg_bit_period = 16'd0;

    logic        in_stall;
    logic        out_valid;
    logic        out_tx_level;
    logic        out_tx_accepted;
    logic        out_tx_done;
    logic        out_rx_done;
    logic [7:0]  out_rx_byte;
    logic        out_rx_frame_error;
    logic        out_busy_res;
    logic        cfg_ready;

    uart_scoreboard scoreboard = new();
    int unsigned    items_sent     = 0;
    int unsigned    results_taken  = 0;
    int unsigned    cur_period     = hdu_pkg::BIT_PERIOD_RESET;
    bit             sender_burst   = 1'b0;
    bit             receiver_burst = 1'b0;

    half_duplex_uart_8n1 dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_level       (rx_level),
        .i_tx_request     (tx_request),
        .i_tx_data        (tx_data),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_tx_level       (out_tx_level),
        .o_tx_accepted    (out_tx_accepted),
        .o_tx_done        (out_tx_done),
        .o_rx_done        (out_rx_done),
        .o_rx_byte        (out_rx_byte),
        .o_rx_frame_error (out_rx_frame_error),
        .o_busy_res       (out_busy_res),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_bit_period (cfg_bit_period)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // occasional stray request; refused unless the link happens to be idle
    function automatic logic maybe_req();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // Offer one tick after a random gap and hold it until the block takes it.
    task automatic send_item(input logic rx, input logic req, input logic [7:0] data);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_level   <= rx;
        tx_request <= req;
        tx_data    <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        scoreboard.note_input(rx, req, data);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic settle();
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_bit_period(input logic [15:0] period);
        cfg_valid      <= 1'b1;
        cfg_bit_period <= period;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        scoreboard.set_period(period);
        cur_period = period;
    endtask

    // Shape one 8N1 frame on the receive line, with an optional defect.
    task automatic send_rx_frame(input logic [7:0] value, input t_frame_flaw flaw,
                                 input logic req_on_edge);
        int unsigned p;
        int unsigned start_len;
        int unsigned half;
        p    = cur_period;
        half = cur_period >> 1;
        if (flaw == FLAW_RATE) begin
            p = $urandom_range(0, 1) ? cur_period + $urandom_range(1, 2) : cur_period - 1;
        end
        start_len = p;
        if (flaw == FLAW_START) begin
            start_len = (half > 1) ? $urandom_range(1, half - 1) : 1;
        end
        // idle high first so the start bit is seen as a falling edge
        repeat ($urandom_range(1, 3)) send_item(1'b1, maybe_req(), rand_byte());
        send_item(1'b0, req_on_edge, rand_byte());
        for (int unsigned i = 1; i < p; i++) begin
            send_item((i < start_len) ? 1'b0 : 1'b1, maybe_req(), rand_byte());
        end
        for (int b = 0; b < 8; b++) begin
            repeat (p) send_item(value[b], maybe_req(), rand_byte());
        end
        repeat (p) send_item((flaw == FLAW_STOP) ? 1'b0 : 1'b1, maybe_req(), rand_byte());
        // hold the line high past the frame check
        repeat (cur_period + 1 + $urandom_range(0, 3)) begin
            send_item(1'b1, maybe_req(), rand_byte());
        end
    endtask

    // Request a transmission, then tick through it with stray requests and
    // receive-line dips that must be ignored while transmitting.
    task automatic send_tx(input logic [7:0] value);
        int unsigned span;
        span = (cur_period >> 1) + 10 * cur_period + 1;
        send_item(1'b1, 1'b1, value);
        for (int unsigned j = 1; j <= span; j++) begin
            send_item((j < 10 * cur_period) ? ($urandom_range(0, 19) != 0) : 1'b1,
                      ($urandom_range(0, 7) == 0), rand_byte());
        end
    endtask

    task automatic send_noise(input int unsigned count);
        repeat (count) begin
            send_item(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0), rand_byte());
        end
    endtask

    task automatic run_segment();
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        sender_burst = ($urandom_range(0, 4) == 0);
        if (pick < 45) begin
            send_rx_frame(rand_byte(), FLAW_NONE, ($urandom_range(0, 7) == 0));
        end else if (pick < 57) begin
            send_rx_frame(rand_byte(), t_frame_flaw'($urandom_range(1, 3)), 1'b0);
        end else if (pick < 85) begin
            send_tx(rand_byte());
        end else begin
            send_noise($urandom_range(5, 20));
        end
    endtask

    // Reprogram the bit period once the link is quiet, then run random traffic.
    task automatic run_phase(input logic [15:0] period, input int unsigned count);
        int unsigned stop_at;
        settle();
        write_bit_period(period);
        stop_at = items_sent + count;
        while (items_sent < stop_at) run_segment();
    endtask

    // Result side: stall at random, take one transaction, check it. Twice in the
    // run hold off long enough for the output stage to fill and stall the input.
    initial begin : result_sink
        int unsigned      wait_cycles;
        hdu_pkg::t_result got;
        forever begin
            if (results_taken == 120 || results_taken == 520) begin
                wait_cycles = HOLD_CYCLES;
            end else if (receiver_burst) begin
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, 5);
            end
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.tx_level       = out_tx_level;
            got.tx_accepted    = out_tx_accepted;
            got.tx_done        = out_tx_done;
            got.rx_done        = out_rx_done;
            got.rx_byte        = out_rx_byte;
            got.rx_frame_error = out_rx_frame_error;
            got.busy_res       = out_busy_res;
            scoreboard.check_result(got);
            results_taken++;
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: shortest period, edge and request on the same tick, extreme
        // bytes in both directions, a bad stop bit and a runt start bit.
        settle();
        write_bit_period(16'd4);
        send_rx_frame(8'hFF, FLAW_NONE, 1'b1);
        send_tx(8'h00);
        send_tx(8'hFF);
        send_rx_frame(8'h00, FLAW_STOP, 1'b0);
        send_rx_frame(8'hA5, FLAW_START, 1'b0);

        // Random traffic over several bit periods.
        run_phase(16'd4, 170);
        run_phase(16'd5, 120);
        run_phase(16'd7, 100);
        run_phase(16'($urandom_range(6, 12)), 100);
        run_phase(16'd4, 40);

        // Longest period: the timer only counts down within this short stretch.
        settle();
        write_bit_period(16'hFFFF);
        sender_burst = 1'b0;
        send_item(1'b1, 1'b1, rand_byte());
        send_noise(25);

        // drain, then let any stray output show up before the verdict
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (scoreboard.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
